// ----- hdl/mrg_pkg.sv -----
// Shared types, codes and defaults for the memory region guard.
`default_nettype none

package mrg_pkg;

    // Default depth of the region table
    localparam int MAX_REGIONS = 16;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int PID_W   = 16;
    localparam int AVAIL_W = 31;

    // Item kinds
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_EXIT   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // One request as it is broadcast along the cell row
    typedef struct packed {
        logic        [PID_W-1:0]  pid;
        logic signed [ADDR_W-1:0] upper;
        logic signed [ADDR_W-1:0] lower;
        logic        [OP_W-1:0]   op;
    } query_t;

    // Update strobes sent from the controller to every cell
    typedef struct packed {
        logic wr;
        logic clr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/mrg_cell.sv -----
// One table entry of the region guard, with its stage of the match chain.
`default_nettype none

module mrg_cell #(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mrg_pkg::query_t     query,
    input  wire mrg_pkg::cell_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]    wr_index,
    input  wire logic                tok_in,
    input  wire logic                flag_in,
    output logic                     tok_out,
    output logic                     flag_out
);

    logic                              valid_reg;
    logic                              live_reg;
    logic signed [mrg_pkg::ADDR_W-1:0] lower_reg;
    logic signed [mrg_pkg::ADDR_W-1:0] upper_reg;
    logic        [mrg_pkg::PID_W-1:0]  owner_reg;
    logic                              tok_reg;
    logic                              flag_reg;

    logic in_use;
    logic apart;
    logic inside_region;
    logic owner_hit;
    logic match;
    logic selected;

    // Compare the broadcast request against this entry
    always_comb
    begin
        in_use        = valid_reg && live_reg;
        owner_hit     = (owner_reg == query.pid);
        apart         = ((query.upper > upper_reg) && (query.lower > upper_reg)) ||
                        ((query.upper < lower_reg) && (query.lower < lower_reg));
        inside_region = (query.upper <= upper_reg) && (query.lower >= lower_reg);
        case (query.op)
            mrg_pkg::OP_ALLOC:  match = in_use && !apart;
            mrg_pkg::OP_ACCESS: match = in_use && owner_hit && inside_region;
            default:            match = 1'b0;
        endcase
        selected = (wr_index == IDX_W'(CELL_INDEX));
    end

    // Advance the token and fold this entry into the running flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            flag_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (tok_in)
            begin
                flag_reg <= flag_in || match;
            end
        end
    end

    // Hold the entry status: append, clear, or drop the live mark on exit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else if (ctrl.wr && selected)
        begin
            valid_reg <= 1'b1;
            live_reg  <= 1'b1;
        end
        else if (tok_in && (query.op == mrg_pkg::OP_EXIT) && valid_reg && owner_hit)
        begin
            live_reg <= 1'b0;
        end
    end

    // Load the entry payload on append
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && selected)
        begin
            lower_reg <= query.lower;
            upper_reg <= query.upper;
            owner_reg <= query.pid;
        end
    end

    assign tok_out  = tok_reg;
    assign flag_out = flag_reg;

endmodule

`default_nettype wire

// ----- hdl/memory_region_guard_unit.sv -----
// Top level of the memory region guard: stream ports, control and the cell row.
//
// The unit keeps a table of up to MAX_REGIONS address regions, one per cell in a
// row of cells. Each item is taken one at a time: after acceptance a token walks
// the row one cell per clock, every cell folding its overlap or containment test
// into a flag that travels with the token, and process exits drop live marks as
// the token passes. The request is registered on acceptance, a launch pulse
// starts the walk, the flag is held as the token leaves the last cell and the
// result is issued from the done state; only then can the next item be taken.
// Appends and table clears take effect when the result is issued. The result
// register lets the next item be accepted and walked while a result waits, but
// that item's result is issued only once the waiting one is taken. The user must
// write mem_available through cfg_wr_en / cfg_wr_data only while the unit is
// idle; the block does not enforce this. There is no clearing pass after reset.
`default_nettype none

module memory_region_guard_unit #(
    parameter int MAX_REGIONS = mrg_pkg::MAX_REGIONS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: mem_available
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // op[1:0], lower_bound[33:2], upper_bound[65:34],
                                        // pid[81:66], zero[87:82]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // fault[0], zero[7:1]
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    mrg_pkg::query_t                    query_reg;
    logic [mrg_pkg::AVAIL_W-1:0]        avail_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               launch_reg;
    logic                               flag_hold_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_fault_reg;
    logic                               out_fault_next;

    logic [MAX_REGIONS:0]               tok;
    logic [MAX_REGIONS:0]               flag;
    mrg_pkg::cell_ctrl_t                ctrl;
    logic                               accept;
    logic                               issue;
    logic                               range_bad;
    logic                               table_full;
    logic                               fault;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_fault_reg};

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            avail_reg <= cfg_wr_data;
        end
    end

    // Capture the request on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= mrg_pkg::query_t'(s_tdata[81:0]);
        end
    end

    // Chain of cells, one entry each
    assign tok[0]  = launch_reg;
    assign flag[0] = 1'b0;

    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        mrg_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .query    (query_reg),
            .ctrl     (ctrl),
            .wr_index (count_reg[IDX_W-1:0]),
            .tok_in   (tok[i]),
            .flag_in  (flag[i]),
            .tok_out  (tok[i+1]),
            .flag_out (flag[i+1])
        );
    end

    // Decide the result once the walk is over
    always_comb
    begin
        range_bad  = query_reg.lower[mrg_pkg::ADDR_W-1] ||
                     (!query_reg.upper[mrg_pkg::ADDR_W-1] &&
                      (query_reg.upper[mrg_pkg::AVAIL_W-1:0] > avail_reg));
        table_full = (count_reg == CNT_W'(MAX_REGIONS));
        case (query_reg.op)
            mrg_pkg::OP_ALLOC:  fault = range_bad || flag_hold_reg || table_full;
            mrg_pkg::OP_ACCESS: fault = range_bad || !flag_hold_reg;
            default:            fault = 1'b0;
        endcase
    end

    // Sequence one item: launch, walk, issue
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_fault_next = out_fault_reg;
        count_next     = count_reg;
        issue          = 1'b0;
        ctrl.wr        = 1'b0;
        ctrl.clr       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tok[MAX_REGIONS])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    issue          = 1'b1;
                    out_valid_next = 1'b1;
                    out_fault_next = fault;
                    state_next     = ST_IDLE;
                    if (query_reg.op == mrg_pkg::OP_ALLOC && !fault)
                    begin
                        ctrl.wr    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (query_reg.op == mrg_pkg::OP_CLEAR)
                    begin
                        ctrl.clr   = 1'b1;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= accept;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and the flag at the end of the row
    always_ff @(posedge clk)
    begin
        out_fault_reg <= out_fault_next;
        if (tok[MAX_REGIONS])
        begin
            flag_hold_reg <= flag[MAX_REGIONS];
        end
    end

    // The token leaves the row only during a walk
    a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_REGIONS] |-> (state_reg == ST_WALK))
        else $error("token left the cell row outside a walk");

    // An accepted item always starts a walk with a launch pulse
    a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (launch_reg && state_reg == ST_WALK))
        else $error("accepted item did not launch a walk");

    // The fill count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count above table depth");

    // A new result appears only when an item finishes
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE && state_reg == ST_IDLE))
        else $error("result issued without a finished item");

    // Table updates happen only when a result is issued
    a_update_on_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr || ctrl.clr) |-> issue)
        else $error("table updated outside result issue");

endmodule

`default_nettype wire
